// ===== sv/sdf_pkg.sv =====
// Shared types, constants and helper functions of the segment display framer.
`default_nettype none
package sdf_pkg;

	// Field widths
	localparam int VALUE_W = 16;
	localparam int BYTE_W  = 8;
	localparam int SHOWN_W = 14;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register map (word index)
	localparam logic [PADDR_W-3:0] REG_DATA_COMMAND = 1'b0;
	localparam logic [BYTE_W-1:0]  DATA_COMMAND_RST = 8'h44;

	// Display limits and bus codes
	localparam logic [VALUE_W-1:0] MAX_SHOWN_IN = 16'd9999;
	localparam logic [SHOWN_W-1:0] MAX_SHOWN    = 14'd9999;
	localparam logic [BYTE_W-1:0]  GRID_BASE    = 8'hC0;
	localparam logic [BYTE_W-1:0]  SEG_BLANK    = 8'h00;

	// Decimal weights of the digit stages
	localparam logic [SHOWN_W-1:0] UNIT_THOU = 14'd1000;
	localparam logic [SHOWN_W-1:0] UNIT_HUND = 14'd100;
	localparam logic [SHOWN_W-1:0] UNIT_TEN  = 14'd10;

	// Byte sequence of one item
	localparam int                 BYTE_IDX_W = 4;
	localparam logic [BYTE_IDX_W-1:0] IDX_CMD  = 4'd0;
	localparam logic [BYTE_IDX_W-1:0] IDX_LAST = 4'd8;

	typedef logic [3:0]        digit_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// Four grid segment codes, thousands at index 0
	typedef struct packed {
		byte_t [3:0] seg;
	} frame_t;

	// One decimal digit and what is left below its weight
	typedef struct packed {
		digit_t             digit;
		logic [SHOWN_W-1:0] rem;
	} split_t;

	// Peel one digit off by comparing against its nine multiples
	function automatic split_t split_digit(input logic [SHOWN_W-1:0] r,
		input logic [SHOWN_W-1:0] unit);
		split_t             s;
		logic [SHOWN_W-1:0] thr;
		s.digit = '0;
		s.rem   = r;
		for (int k = 1; k <= 9; k++) begin
			thr = SHOWN_W'(k) * unit;
			if (r >= thr) begin
				s.digit = digit_t'(k);
				s.rem   = r - thr;
			end
		end
		return s;
	endfunction

	// Seven-segment code, bit 0 = segment a
	function automatic byte_t seg_of_digit(input digit_t d);
		byte_t c;
		case (d)
			4'd0:    c = 8'h3F;
			4'd1:    c = 8'h06;
			4'd2:    c = 8'h5B;
			4'd3:    c = 8'h4F;
			4'd4:    c = 8'h66;
			4'd5:    c = 8'h6D;
			4'd6:    c = 8'h7D;
			4'd7:    c = 8'h07;
			4'd8:    c = 8'h7F;
			4'd9:    c = 8'h6F;
			default: c = SEG_BLANK;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/sdf_if.sv =====
// Valid/ready channel interfaces for the number input and the bus byte output.
`default_nettype none
interface sdf_value_if;
	import sdf_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface sdf_byte_if;
	import sdf_pkg::*;
	logic  valid;
	logic  ready;
	byte_t bus_byte;
	logic  starts_frame;
	logic  ends_frame;
	logic  last;

	modport source (output valid, output bus_byte, output starts_frame,
		output ends_frame, output last, input ready);
	modport sink   (input valid, input bus_byte, input starts_frame,
		input ends_frame, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/sdf_cfg.sv =====
// APB-style register file holding the data command byte.
`default_nettype none
module sdf_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sdf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sdf_pkg::PDATA_W-1:0] pwdata,
	output logic      [sdf_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output sdf_pkg::byte_t                   data_command
);
	import sdf_pkg::*;

	logic                 wr_en;
	logic [PADDR_W-3:0]   reg_idx;
	byte_t                data_command_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Capture the command byte on the access cycle; drop writes elsewhere
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_command_q <= DATA_COMMAND_RST;
		end else if (wr_en && reg_idx == REG_DATA_COMMAND) begin
			data_command_q <= pwdata[BYTE_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_DATA_COMMAND) begin
			prdata = {{(PDATA_W-BYTE_W){1'b0}}, data_command_q};
		end
	end

	assign data_command = data_command_q;
endmodule
`default_nettype wire

// ===== sv/sdf_digits.sv =====
// Clamp, decimal split, leading-zero blanking and segment lookup pipeline.
`default_nettype none
module sdf_digits (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sdf_value_if.sink        value_ch,
	output logic             frm_valid,
	output sdf_pkg::frame_t  frm,
	input  wire logic        frm_ready
);
	import sdf_pkg::*;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               adv1, adv2, adv3, adv4;
	logic [SHOWN_W-1:0] val_s1;
	logic [SHOWN_W-1:0] val_in;
	digit_t             th_s2, th_s3, hu_s3;
	logic [9:0]         rem_s2;
	logic [6:0]         rem_s3;
	split_t             sp2, sp3, sp4;
	frame_t             seg_s4;
	frame_t             seg_nx;
	logic               show_th, show_hu, show_te;

	// Each stage moves when it is empty or its contents move on
	assign adv4           = !vld_s4 || frm_ready;
	assign adv3           = !vld_s3 || adv4;
	assign adv2           = !vld_s2 || adv3;
	assign adv1           = !vld_s1 || adv2;
	assign value_ch.ready = adv1;

	// Saturate to the largest four-digit number
	assign val_in = (value_ch.value > MAX_SHOWN_IN) ? MAX_SHOWN
		: value_ch.value[SHOWN_W-1:0];

	assign sp2 = split_digit(val_s1, UNIT_THOU);
	assign sp3 = split_digit({4'b0, rem_s2}, UNIT_HUND);
	assign sp4 = split_digit({7'b0, rem_s3}, UNIT_TEN);

	// Blank leading zeros; the units digit always shows
	always_comb begin
		show_th = th_s3 != 4'd0;
		show_hu = show_th || hu_s3 != 4'd0;
		show_te = show_hu || sp4.digit != 4'd0;
		seg_nx.seg[0] = show_th ? seg_of_digit(th_s3) : SEG_BLANK;
		seg_nx.seg[1] = show_hu ? seg_of_digit(hu_s3) : SEG_BLANK;
		seg_nx.seg[2] = show_te ? seg_of_digit(sp4.digit) : SEG_BLANK;
		seg_nx.seg[3] = seg_of_digit(sp4.rem[3:0]);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= value_ch.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv1) begin
			val_s1 <= val_in;
		end
		if (adv2) begin
			th_s2  <= sp2.digit;
			rem_s2 <= sp2.rem[9:0];
		end
		if (adv3) begin
			th_s3  <= th_s2;
			hu_s3  <= sp3.digit;
			rem_s3 <= sp3.rem[6:0];
		end
		if (adv4) begin
			seg_s4 <= seg_nx;
		end
	end

	assign frm_valid = vld_s4;
	assign frm       = seg_s4;
endmodule
`default_nettype wire

// ===== sv/sdf_ser.sv =====
// Frame serialiser: emits the nine bus bytes of one item, one per cycle while the bus is ready.
`default_nettype none
module sdf_ser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            frm_valid,
	input  wire sdf_pkg::frame_t frm,
	output logic                 frm_ready,
	input  wire sdf_pkg::byte_t  data_command,
	sdf_byte_if.source           byte_ch
);
	import sdf_pkg::*;

	logic                  busy_q;
	logic [BYTE_IDX_W-1:0] idx_q;
	frame_t                seg_q;
	logic                  take;
	logic [1:0]            grid;
	logic [1:0]            seg_sel;

	assign take      = byte_ch.valid && byte_ch.ready;
	assign frm_ready = !busy_q || (take && idx_q == IDX_LAST);

	// Load a new frame on the last byte or when idle; otherwise advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= IDX_CMD;
		end else if (frm_ready) begin
			busy_q <= frm_valid;
			idx_q  <= IDX_CMD;
		end else if (take) begin
			idx_q  <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (frm_ready) begin
			seg_q <= frm;
		end
	end

	// Odd bytes carry the grid address, even ones after the command byte the segment code
	assign grid    = idx_q[2:1];
	assign seg_sel = 2'(idx_q[3:1] - 3'd1);

	always_comb begin
		byte_ch.valid        = busy_q;
		byte_ch.last         = idx_q == IDX_LAST;
		if (idx_q == IDX_CMD) begin
			byte_ch.bus_byte     = data_command;
			byte_ch.starts_frame = 1'b1;
			byte_ch.ends_frame   = 1'b1;
		end else if (idx_q[0]) begin
			byte_ch.bus_byte     = GRID_BASE + {6'b0, grid};
			byte_ch.starts_frame = 1'b1;
			byte_ch.ends_frame   = 1'b0;
		end else begin
			byte_ch.bus_byte     = seg_q.seg[seg_sel];
			byte_ch.starts_frame = 1'b0;
			byte_ch.ends_frame   = 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== sv/four_digit_segment_display_framer_core.sv =====
// Top level of the four-digit segment display framer.
//
//  channel   dir  handshake         payload
//  value_ch  in   valid/ready       value[15:0]
//  byte_ch   out  valid/ready       bus_byte[7:0], starts_frame, ends_frame, last
//  apb       in   psel/penable      paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Each number yields nine bus bytes, one per cycle while the output accepts
// them, emitted by the byte serialiser. A number passes a four-stage digit
// pipeline before reaching the serialiser, which loads the next frame in the
// same cycle as its last byte is taken. A stalled output
// holds the current byte and backs the pipeline up to the input ready.
// Reset empties the pipeline and sets the data command to 0x44.
`default_nettype none
module four_digit_segment_display_framer_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sdf_value_if.sink                        value_ch,
	sdf_byte_if.source                       byte_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sdf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sdf_pkg::PDATA_W-1:0] pwdata,
	output logic      [sdf_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import sdf_pkg::*;

	byte_t  data_command;
	logic   frm_valid;
	logic   frm_ready;
	frame_t frm;

	sdf_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.data_command (data_command)
	);

	sdf_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_ch  (value_ch),
		.frm_valid (frm_valid),
		.frm       (frm),
		.frm_ready (frm_ready)
	);

	sdf_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.frm_valid    (frm_valid),
		.frm          (frm),
		.frm_ready    (frm_ready),
		.data_command (data_command),
		.byte_ch      (byte_ch)
	);
endmodule
`default_nettype wire
